### rtl/c8ex_pkg.sv
// Shared types and constants of the CHIP-8 instruction executor.
// Holds the micro-operation codes, controller states, instruction field
// codes and the command and status structs; depends on nothing.
package c8ex_pkg;

  localparam int FRAME_W = 64;
  localparam int FRAME_H = 32;

  localparam logic [11:0] PC_RESET   = 12'h200;
  localparam logic [11:0] FONT_RESET = 12'h050;

  localparam logic [3:0] CFG_FONT = 4'd1;

  localparam logic [1:0] OP_WRMEM = 2'd0;
  localparam logic [1:0] OP_EXEC  = 2'd1;
  localparam logic [1:0] OP_RDPIX = 2'd2;
  localparam logic [1:0] OP_RDMEM = 2'd3;

  localparam logic [1:0] FLT_NONE = 2'd0;
  localparam logic [1:0] FLT_OVF  = 2'd1;
  localparam logic [1:0] FLT_UNF  = 2'd2;

  localparam logic [3:0] OPC_SYS  = 4'h0;
  localparam logic [3:0] OPC_JP   = 4'h1;
  localparam logic [3:0] OPC_CALL = 4'h2;
  localparam logic [3:0] OPC_SEQI = 4'h3;
  localparam logic [3:0] OPC_SNEI = 4'h4;
  localparam logic [3:0] OPC_SEQR = 4'h5;
  localparam logic [3:0] OPC_LDI  = 4'h6;
  localparam logic [3:0] OPC_ADDI = 4'h7;
  localparam logic [3:0] OPC_ALU  = 4'h8;
  localparam logic [3:0] OPC_SNER = 4'h9;
  localparam logic [3:0] OPC_LDIX = 4'hA;
  localparam logic [3:0] OPC_JPV0 = 4'hB;
  localparam logic [3:0] OPC_RND  = 4'hC;
  localparam logic [3:0] OPC_DRW  = 4'hD;
  localparam logic [3:0] OPC_KEY  = 4'hE;
  localparam logic [3:0] OPC_MISC = 4'hF;

  localparam logic [3:0] ALU_MOV = 4'h0;
  localparam logic [3:0] ALU_OR  = 4'h1;
  localparam logic [3:0] ALU_AND = 4'h2;
  localparam logic [3:0] ALU_XOR = 4'h3;
  localparam logic [3:0] ALU_ADD = 4'h4;
  localparam logic [3:0] ALU_SUB = 4'h5;
  localparam logic [3:0] ALU_SHR = 4'h6;
  localparam logic [3:0] ALU_SBN = 4'h7;
  localparam logic [3:0] ALU_SHL = 4'hE;

  localparam logic [7:0] NN_CLS   = 8'hE0;
  localparam logic [7:0] NN_RET   = 8'hEE;
  localparam logic [7:0] NN_SKP   = 8'h9E;
  localparam logic [7:0] NN_SKNP  = 8'hA1;
  localparam logic [7:0] NN_WAITK = 8'h0A;
  localparam logic [7:0] NN_ADDIX = 8'h1E;
  localparam logic [7:0] NN_FONT  = 8'h29;
  localparam logic [7:0] NN_BCD   = 8'h33;
  localparam logic [7:0] NN_STORE = 8'h55;
  localparam logic [7:0] NN_LOAD  = 8'h65;

  typedef enum logic [3:0] {
    U_NOP, U_LATCH, U_SEL, U_F1, U_F2, U_EXE, U_RETW, U_VFW,
    U_DRD, U_DWR, U_BCD, U_SRD, U_SWR, U_LRD, U_LWR, U_FIN
  } uop_e;

  typedef enum logic [4:0] {
    S_IDLE, S_SEL, S_MRDW, S_PRDW, S_F1, S_F2, S_DEC, S_EXE, S_RETW,
    S_VFW, S_DRD, S_DWR, S_BCD, S_SRD, S_SWR, S_LRD, S_LWR, S_FIN
  } state_e;

  typedef struct packed {
    uop_e uop;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic [3:0] opc;
    logic [3:0] x;
    logic [7:0] nn;
    logic [3:0] n;
    logic       row_more;
    logic       cnt_eq_x;
    logic       cnt_eq2;
    logic       stk_empty;
  } stat_t;

endpackage

### rtl/c8ex_ctrl.sv
// Controller state machine of the CHIP-8 executor.
// Sequences memory and pixel accesses, fetch, execute and the row, digit and register loops; uses c8ex_pkg.
module c8ex_ctrl import c8ex_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t st_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic   ov_q, ov_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ov_q;

  always_comb begin
    state_d   = state_q;
    cmd_o.uop = U_NOP;
    ov_d      = ov_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.uop = U_LATCH;
          state_d   = S_SEL;
        end
      end
      S_SEL: begin
        cmd_o.uop = U_SEL;
        case (st_i.op)
          OP_WRMEM: state_d = S_FIN;
          OP_RDMEM: state_d = S_MRDW;
          OP_RDPIX: state_d = S_PRDW;
          default:  state_d = S_F1;
        endcase
      end
      S_MRDW, S_PRDW: begin
        cmd_o.uop = U_F2;
        state_d   = S_FIN;
      end
      S_F1: begin
        cmd_o.uop = U_F1;
        state_d   = S_F2;
      end
      S_F2: begin
        cmd_o.uop = U_F2;
        state_d   = S_DEC;
      end
      S_DEC: state_d = S_EXE;
      S_EXE: begin
        cmd_o.uop = U_EXE;
        state_d   = S_FIN;
        case (st_i.opc)
          OPC_SYS: begin
            if (st_i.x == 4'h0 && st_i.nn == NN_RET && !st_i.stk_empty) begin
              state_d = S_RETW;
            end
          end
          OPC_ALU: begin
            if (st_i.n == ALU_ADD || st_i.n == ALU_SUB || st_i.n == ALU_SHR ||
                st_i.n == ALU_SBN || st_i.n == ALU_SHL) begin
              state_d = S_VFW;
            end
          end
          OPC_DRW: state_d = S_DRD;
          OPC_MISC: begin
            if (st_i.nn == NN_BCD) begin
              state_d = S_BCD;
            end else if (st_i.nn == NN_STORE) begin
              state_d = S_SRD;
            end else if (st_i.nn == NN_LOAD) begin
              state_d = S_LRD;
            end
          end
          default: state_d = S_FIN;
        endcase
      end
      S_RETW: begin
        cmd_o.uop = U_RETW;
        state_d   = S_FIN;
      end
      S_VFW: begin
        cmd_o.uop = U_VFW;
        state_d   = S_FIN;
      end
      S_DRD: begin
        if (st_i.row_more) begin
          cmd_o.uop = U_DRD;
          state_d   = S_DWR;
        end else begin
          state_d = S_VFW;
        end
      end
      S_DWR: begin
        cmd_o.uop = U_DWR;
        state_d   = S_DRD;
      end
      S_BCD: begin
        cmd_o.uop = U_BCD;
        if (st_i.cnt_eq2) begin
          state_d = S_FIN;
        end
      end
      S_SRD: begin
        cmd_o.uop = U_SRD;
        state_d   = S_SWR;
      end
      S_SWR: begin
        cmd_o.uop = U_SWR;
        state_d   = st_i.cnt_eq_x ? S_FIN : S_SRD;
      end
      S_LRD: begin
        cmd_o.uop = U_LRD;
        state_d   = S_LWR;
      end
      S_LWR: begin
        cmd_o.uop = U_LWR;
        state_d   = st_i.cnt_eq_x ? S_FIN : S_LRD;
      end
      S_FIN: begin
        if (!ov_q || out_ready_i) begin
          cmd_o.uop = U_FIN;
          ov_d      = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

### rtl/c8ex_dp.sv
// Datapath of the CHIP-8 executor: memory, frame, registers, stack and ALU.
// Acts on micro-operations from c8ex_ctrl; uses c8ex_pkg.
module c8ex_dp import c8ex_pkg::*; #(
  parameter int MEM_BYTES   = 4096,
  parameter int STACK_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output stat_t       st_o,
  input  logic [1:0]  op_i,
  input  logic [11:0] address_i,
  input  logic [7:0]  write_data_i,
  input  logic [15:0] key_state_i,
  input  logic [4:0]  last_key_i,
  input  logic [7:0]  random_byte_i,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i,
  output logic [11:0] program_counter_o,
  output logic [11:0] index_value_o,
  output logic [7:0]  read_value_o,
  output logic        drew_sprite_o,
  output logic        waiting_key_o,
  output logic [1:0]  fault_o
);

  localparam int MAW = $clog2(MEM_BYTES);
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int DW  = $clog2(STACK_DEPTH + 1);
  localparam int RAW = $clog2(FRAME_H);
  localparam int CAW = $clog2(FRAME_W);
  localparam logic [12:0] MB    = 13'(MEM_BYTES);
  localparam logic [DW-1:0] SDEP = DW'(STACK_DEPTH);

  // Addresses wrap at 12 bits and then fold into the memory size.
  function automatic logic [MAW-1:0] mem_ix(input logic [11:0] a);
    logic [12:0] r;
    r = {1'b0, a};
    for (int k = 0; k < 7; k++) begin
      if (r >= MB) r = r - MB;
    end
    return r[MAW-1:0];
  endfunction

  logic [7:0]         mem [MEM_BYTES];
  logic [7:0]         mrd_q;
  logic [7:0]         vreg [16];
  logic [15:0]        vvld_q;
  logic [7:0]         va_raw_q, vb_raw_q;
  logic               va_v_q, vb_v_q;
  logic [11:0]        stk [STACK_DEPTH];
  logic [11:0]        srd_q;
  logic [FRAME_W-1:0] frm [FRAME_H];
  logic [FRAME_H-1:0] fvld_q;
  logic [FRAME_W-1:0] frd_raw_q;
  logic               frd_v_q;

  logic [1:0]  op_q;
  logic [11:0] addr_q;
  logic [7:0]  wdata_q, rnd_q;
  logic [15:0] keys_q;
  logic [4:0]  lkey_q;
  logic [15:0] ins_q;
  logic [11:0] pc_q, pcn_q, idx_q, font_q;
  logic [3:0]  cnt_q;
  logic        flag_q;
  logic [CAW-1:0] ox_q;
  logic [RAW-1:0] oy_q;
  logic [7:0]  readv_q;
  logic        drew_q, wait_q;
  logic [1:0]  fault_q;
  logic [DW-1:0] depth_q;

  logic [3:0]  opc, x, y, n;
  logic [7:0]  nn, vx, vy;
  logic [11:0] nnn, icnt;
  logic [FRAME_W-1:0] frow, smask;
  logic [RAW:0]   drow6;
  logic [RAW-1:0] frd_addr;
  logic [3:0]  va_addr, vb_addr;
  logic [11:0] mra12, mwa12, pc_exe, idx_exe;
  logic [7:0]  mwd, vwd;
  logic        mwe, vwe, flag_exe, full, empty, cls, ret, held, nokey;
  logic [8:0]  sum9;
  logic [1:0]  hund;
  logic [6:0]  rem;
  logic [14:0] tprod;
  logic [3:0]  tens, ones;
  logic [11:0] pc_fin;

  assign opc   = ins_q[15:12];
  assign x     = ins_q[11:8];
  assign y     = ins_q[7:4];
  assign n     = ins_q[3:0];
  assign nn    = ins_q[7:0];
  assign nnn   = ins_q[11:0];
  assign vx    = va_v_q ? va_raw_q : 8'h00;
  assign vy    = vb_v_q ? vb_raw_q : 8'h00;
  assign icnt  = idx_q + {8'h00, cnt_q};
  assign frow  = frd_v_q ? frd_raw_q : '0;
  assign smask = {mrd_q, {(FRAME_W - 8){1'b0}}} >> ox_q;
  assign drow6 = {1'b0, oy_q} + (RAW + 1)'(cnt_q);
  assign full  = (depth_q >= SDEP);
  assign empty = (depth_q == '0);
  assign cls   = (opc == OPC_SYS) && (x == 4'h0) && (nn == NN_CLS);
  assign ret   = (opc == OPC_SYS) && (x == 4'h0) && (nn == NN_RET);
  assign held  = keys_q[vx[3:0]];
  assign nokey = lkey_q[4];
  assign sum9  = {1'b0, vx} + {1'b0, vy};

  // Decimal digits of Vx: hundreds by compare, tens by reciprocal multiply.
  assign hund  = (vx >= 8'd200) ? 2'd2 : ((vx >= 8'd100) ? 2'd1 : 2'd0);
  assign rem   = 7'(vx - 8'(hund) * 8'd100);
  assign tprod = 15'(rem) * 15'd205;
  assign tens  = tprod[14:11];
  assign ones  = 4'(rem - 7'(tens) * 7'd10);

  assign st_o.op        = op_q;
  assign st_o.opc       = opc;
  assign st_o.x         = x;
  assign st_o.nn        = nn;
  assign st_o.n         = n;
  assign st_o.row_more  = (cnt_q < n) && !drow6[RAW];
  assign st_o.cnt_eq_x  = (cnt_q == x);
  assign st_o.cnt_eq2   = (cnt_q == 4'd2);
  assign st_o.stk_empty = empty;

  assign va_addr  = (cmd_i.uop == U_SRD) ? cnt_q : x;
  assign vb_addr  = (opc == OPC_JPV0) ? 4'h0 : y;
  assign frd_addr = (op_q == OP_RDPIX && cmd_i.uop == U_SEL) ? addr_q[10:6]
                                                              : drow6[RAW-1:0];
  assign pc_fin   = (op_q == OP_EXEC) ? pcn_q : pc_q;

  always_comb begin
    case (cmd_i.uop)
      U_SEL:        mra12 = (op_q == OP_EXEC) ? pc_q : addr_q;
      U_F1:         mra12 = pc_q + 12'd1;
      U_DRD, U_LRD: mra12 = icnt;
      default:      mra12 = addr_q;
    endcase
    mwe   = 1'b0;
    mwa12 = icnt;
    mwd   = vx;
    case (cmd_i.uop)
      U_SEL: begin
        mwe   = (op_q == OP_WRMEM);
        mwa12 = addr_q;
        mwd   = wdata_q;
      end
      U_BCD: begin
        mwe = 1'b1;
        case (cnt_q[1:0])
          2'd0:    mwd = {6'd0, hund};
          2'd1:    mwd = {4'd0, tens};
          default: mwd = {4'd0, ones};
        endcase
      end
      U_SWR:   mwe = 1'b1;
      default: mwe = 1'b0;
    endcase
  end

  // Combinational effects of the instruction, applied in the execute step.
  always_comb begin
    pc_exe   = pc_q + 12'd2;
    idx_exe  = idx_q;
    vwe      = 1'b0;
    vwd      = nn;
    flag_exe = 1'b0;
    case (opc)
      OPC_JP:   pc_exe = nnn;
      OPC_CALL: if (!full) pc_exe = nnn;
      OPC_SEQI: if (vx == nn) pc_exe = pc_q + 12'd4;
      OPC_SNEI: if (vx != nn) pc_exe = pc_q + 12'd4;
      OPC_SEQR: if (vx == vy) pc_exe = pc_q + 12'd4;
      OPC_SNER: if (vx != vy) pc_exe = pc_q + 12'd4;
      OPC_LDI:  vwe = 1'b1;
      OPC_ADDI: begin
        vwe = 1'b1;
        vwd = vx + nn;
      end
      OPC_ALU: begin
        vwe = 1'b1;
        case (n)
          ALU_MOV: vwd = vy;
          ALU_OR:  vwd = vx | vy;
          ALU_AND: vwd = vx & vy;
          ALU_XOR: vwd = vx ^ vy;
          ALU_ADD: begin
            vwd      = sum9[7:0];
            flag_exe = sum9[8];
          end
          ALU_SUB: begin
            vwd      = vx - vy;
            flag_exe = (vx >= vy);
          end
          ALU_SHR: begin
            vwd      = {1'b0, vx[7:1]};
            flag_exe = vx[0];
          end
          ALU_SBN: begin
            vwd      = vy - vx;
            flag_exe = (vy >= vx);
          end
          ALU_SHL: begin
            vwd      = {vx[6:0], 1'b0};
            flag_exe = vx[7];
          end
          default: vwe = 1'b0;
        endcase
      end
      OPC_LDIX: idx_exe = nnn;
      OPC_JPV0: pc_exe = nnn + {4'h0, vy};
      OPC_RND: begin
        vwe = 1'b1;
        vwd = rnd_q & nn;
      end
      OPC_KEY: begin
        if ((nn == NN_SKP && held) || (nn == NN_SKNP && !held)) begin
          pc_exe = pc_q + 12'd4;
        end
      end
      OPC_MISC: begin
        case (nn)
          NN_WAITK: begin
            if (nokey) begin
              pc_exe = pc_q;
            end else begin
              vwe = 1'b1;
              vwd = {4'h0, lkey_q[3:0]};
            end
          end
          NN_ADDIX: idx_exe = idx_q + {4'h0, vx};
          NN_FONT:  idx_exe = font_q + {6'd0, vx[3:0], 2'b00} + {8'd0, vx[3:0]};
          default:  idx_exe = idx_q;
        endcase
      end
      default: pc_exe = pc_q + 12'd2;
    endcase
  end

  always_ff @(posedge clk_i) begin
    mrd_q <= mem[mem_ix(mra12)];
    if (mwe) mem[mem_ix(mwa12)] <= mwd;
    va_raw_q  <= vreg[va_addr];
    vb_raw_q  <= vreg[vb_addr];
    srd_q     <= stk[SAW'(depth_q - DW'(1))];
    frd_raw_q <= frm[frd_addr];
    if (cmd_i.uop == U_EXE && vwe) vreg[x] <= vwd;
    if (cmd_i.uop == U_VFW) vreg[4'hF] <= {7'd0, flag_q};
    if (cmd_i.uop == U_LWR) vreg[cnt_q] <= mrd_q;
    if (cmd_i.uop == U_EXE && opc == OPC_CALL && !full) begin
      stk[depth_q[SAW-1:0]] <= pc_q + 12'd2;
    end
    if (cmd_i.uop == U_DWR) frm[drow6[RAW-1:0]] <= frow ^ smask;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vvld_q  <= '0;
      va_v_q  <= 1'b0;
      vb_v_q  <= 1'b0;
      fvld_q  <= '0;
      frd_v_q <= 1'b0;
      pc_q    <= PC_RESET;
      idx_q   <= 12'h000;
      font_q  <= FONT_RESET;
      depth_q <= '0;
    end else begin
      va_v_q  <= vvld_q[va_addr];
      vb_v_q  <= vvld_q[vb_addr];
      frd_v_q <= fvld_q[frd_addr];
      if (cfg_we_i && cfg_index_i == CFG_FONT) font_q <= cfg_data_i;
      case (cmd_i.uop)
        U_EXE: begin
          idx_q <= idx_exe;
          if (vwe) vvld_q[x] <= 1'b1;
          if (cls) fvld_q <= '0;
          if (opc == OPC_CALL && !full) depth_q <= depth_q + DW'(1);
          if (ret && !empty) depth_q <= depth_q - DW'(1);
        end
        U_VFW:   vvld_q[4'hF] <= 1'b1;
        U_LWR:   vvld_q[cnt_q] <= 1'b1;
        U_DWR:   fvld_q[drow6[RAW-1:0]] <= 1'b1;
        U_FIN:   pc_q <= pc_fin;
        default: pc_q <= pc_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.uop)
      U_LATCH: begin
        op_q    <= op_i;
        addr_q  <= address_i;
        wdata_q <= write_data_i;
        keys_q  <= key_state_i;
        lkey_q  <= last_key_i;
        rnd_q   <= random_byte_i;
        readv_q <= 8'h00;
        drew_q  <= 1'b0;
        wait_q  <= 1'b0;
        fault_q <= FLT_NONE;
      end
      U_F1: ins_q[15:8] <= mrd_q;
      U_F2: begin
        // Also completes the single-read items.
        ins_q[7:0] <= mrd_q;
        if (op_q == OP_RDMEM) readv_q <= mrd_q;
        if (op_q == OP_RDPIX) readv_q <= {7'd0, frow[~addr_q[CAW-1:0]]};
      end
      U_EXE: begin
        pcn_q  <= pc_exe;
        flag_q <= flag_exe;
        cnt_q  <= 4'h0;
        ox_q   <= vx[CAW-1:0];
        oy_q   <= vy[RAW-1:0];
        drew_q <= cls || (opc == OPC_DRW);
        wait_q <= (opc == OPC_MISC) && (nn == NN_WAITK) && nokey;
        if (opc == OPC_CALL && full) fault_q <= FLT_OVF;
        if (ret && empty) fault_q <= FLT_UNF;
      end
      U_RETW: pcn_q <= srd_q;
      U_DWR: begin
        flag_q <= flag_q | (|(frow & smask));
        cnt_q  <= cnt_q + 4'd1;
      end
      U_BCD, U_SWR, U_LWR: cnt_q <= cnt_q + 4'd1;
      U_FIN: begin
        program_counter_o <= pc_fin;
        index_value_o     <= idx_q;
        read_value_o      <= readv_q;
        drew_sprite_o     <= drew_q;
        waiting_key_o     <= wait_q;
        fault_o           <= fault_q;
      end
      default: cnt_q <= cnt_q;
    endcase
  end

endmodule

### rtl/chip8_instruction_executor_core.sv
// Top level of the CHIP-8 instruction executor.
// Joins the controller c8ex_ctrl and the datapath c8ex_dp; uses c8ex_pkg.
//
// Each accepted item gives exactly one result item. A memory write goes
// through the select and finish steps, memory and pixel reads add a wait
// step, and an instruction adds two fetch steps, decode and execute plus its
// loop: a sprite draw adds a read and a write step per drawn row and a flag
// write, BCD writes its three digits one per step, and a register store or
// load adds a read and a write step per register. The steps follow from the
// registered memory read, which the fetch and every row or register step go
// through. One item is in work at a time; a new item is taken as soon as the
// previous result sits in the output register, even while that result still
// waits to be taken. The frame and the general registers come out of reset
// cleared by per-row and per-register valid bits, so there is no clearing
// pass. The program counter starts at 0x200; a write to start_address (index
// 0) is accepted and has no effect after reset. font_base is register index
// 1; other indexes are ignored.
module chip8_instruction_executor_core import c8ex_pkg::*; #(
  parameter int MEM_BYTES   = 4096,
  parameter int STACK_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [11:0] address_i,
  input  logic [7:0]  write_data_i,
  input  logic [15:0] key_state_i,
  input  logic [4:0]  last_key_i,
  input  logic [7:0]  random_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [11:0] program_counter_o,
  output logic [11:0] index_value_o,
  output logic [7:0]  read_value_o,
  output logic        drew_sprite_o,
  output logic        waiting_key_o,
  output logic [1:0]  fault_o,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i
);

  cmd_t  cmd;
  stat_t st;

  // The controller owns the handshakes and the sequence of steps.
  c8ex_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  // The datapath holds all architectural state and the result register.
  c8ex_dp #(
    .MEM_BYTES  (MEM_BYTES),
    .STACK_DEPTH(STACK_DEPTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .st_o             (st),
    .op_i             (op_i),
    .address_i        (address_i),
    .write_data_i     (write_data_i),
    .key_state_i      (key_state_i),
    .last_key_i       (last_key_i),
    .random_byte_i    (random_byte_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .program_counter_o(program_counter_o),
    .index_value_o    (index_value_o),
    .read_value_o     (read_value_o),
    .drew_sprite_o    (drew_sprite_o),
    .waiting_key_o    (waiting_key_o),
    .fault_o          (fault_o)
  );

endmodule
